// ===== src/lcfc_pkg.sv =====
// Shared widths, register indexes, reset values and status codes of the force conditioner.
`default_nettype none
package lcfc_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int FILTER_SHIFT_DEF = 2;

  localparam int RAW_W      = 24;
  localparam int CPL_W      = 21;
  localparam int DB_W       = 16;
  localparam int STALE_W    = 16;
  localparam int TIME_W     = 32;
  localparam int FORCE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPL         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT = 3'd4;

  localparam logic                      CAL_MODE_RST    = 1'b0;
  localparam logic signed [RAW_W-1:0]   ZERO_OFFSET_RST = 24'sd0;
  localparam logic signed [CPL_W-1:0]   CPL_RST         = 21'sd2280;
  localparam logic [DB_W-1:0]           DEADBAND_RST    = 16'd19661;
  localparam logic [STALE_W-1:0]        STALE_LIMIT_RST = 16'd350;

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = 32'sh8000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRESH = 2'd0,
    ST_HELD  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

endpackage
`default_nettype wire

// ===== src/lcfc_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module lcfc_divider #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] dq;     // dividend bits shift out at the top, quotient bits in at the bottom
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem, dq[NUM_W-1]};
  assign ge        = trial >= {1'b0, den};
  assign trial_sub = trial - {1'b0, den};
  assign quotient  = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= divisor;
      dq  <= dividend;
    end else if (busy) begin
      rem <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      dq  <= {dq[NUM_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== src/load_cell_force_conditioner_unit.sv =====
// Top level of the load cell force conditioner: sequencer, filter state and output register.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     sample_ready, raw_count, now_ms
//   out      source     out_valid / out_ready   force_q16, status
//   cfg      sink       cfg_wr_en               cfg_addr, cfg_wdata
//
// A poll with a sample runs from accept through the serial divider, which gives one
// quotient bit a cycle, then a done flag, saturation, filter update and publish.
// A poll without a sample goes from accept straight to the publish step.
// in_ready is high only while the sequencer is idle; the output register may still
// hold an untaken result then, and the publish step waits on it.
// Synchronous reset clears the filter, the time stamp and out_valid, and sets the configuration registers to defaults.
`default_nettype none
module load_cell_force_conditioner_unit #(
  parameter int FRAC_BITS    = lcfc_pkg::FRAC_BITS_DEF,
  parameter int FILTER_SHIFT = lcfc_pkg::FILTER_SHIFT_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    sample_ready,
  input  logic signed [lcfc_pkg::RAW_W-1:0]       raw_count,
  input  logic        [lcfc_pkg::TIME_W-1:0]      now_ms,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lcfc_pkg::FORCE_W-1:0]     force_q16,
  output logic        [lcfc_pkg::STATUS_W-1:0]    status,
  input  logic                                    cfg_wr_en,
  input  logic        [lcfc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic        [lcfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import lcfc_pkg::*;

  localparam int DIFF_W = RAW_W + 1;
  localparam int NUM_W  = DIFF_W + FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_CONV = 5'b00100,
    S_FILT = 5'b01000,
    S_PUB  = 5'b10000
  } state_t;

  state_t state;

  logic                      calibration_mode;
  logic signed [RAW_W-1:0]   zero_offset;
  logic signed [CPL_W-1:0]   counts_per_lb;
  logic [DB_W-1:0]           deadband_q16;
  logic [STALE_W-1:0]        stale_limit_ms;

  logic signed [FORCE_W-1:0] filtered_force;
  logic                      filter_primed;
  logic [TIME_W-1:0]         last_fresh_time;
  logic [TIME_W-1:0]         now_lat;
  logic                      q_neg;
  logic                      num_zero;
  logic signed [FORCE_W-1:0] conv_force;
  status_t                   st_code;
  logic signed [FORCE_W-1:0] force_out;
  status_t                   status_out;

  logic                      accept;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [CPL_W-1:0]          cpl_mag;
  logic [NUM_W-1:0]          dividend;
  logic [TIME_W-1:0]         elapsed;
  logic                      held_ok;
  logic                      div_done;
  logic [NUM_W-1:0]          quot;
  logic                      ovf_pos;
  logic                      ovf_neg;
  logic signed [FORCE_W-1:0] conv_next;
  logic signed [FORCE_W:0]   fd;
  logic signed [FORCE_W:0]   fstep;
  logic signed [FORCE_W+1:0] fsum;
  logic signed [FORCE_W-1:0] filt_next;
  logic [FORCE_W:0]          f_abs;
  logic signed [FORCE_W-1:0] pub_force;
  logic                      out_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign force_q16 = force_out;
  assign status    = status_out;
  assign out_free  = !out_valid || out_ready;

  // conversion set-up
  assign diff     = {raw_count[RAW_W-1], raw_count} - {zero_offset[RAW_W-1], zero_offset};
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign cpl_mag  = counts_per_lb[CPL_W-1] ? CPL_W'(-counts_per_lb) : CPL_W'(counts_per_lb);
  assign dividend = {diff_mag, {FRAC_BITS{1'b0}}};

  assign elapsed = now_ms - last_fresh_time;
  assign held_ok = filter_primed && (elapsed <= {{(TIME_W-STALE_W){1'b0}}, stale_limit_ms});

  lcfc_divider #(
    .NUM_W(NUM_W),
    .DEN_W(CPL_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && sample_ready),
    .dividend(dividend),
    .divisor (cpl_mag),
    .done    (div_done),
    .quotient(quot)
  );

  // sign and saturation; a zero divisor leaves an all-ones quotient, which saturates unless the difference is zero
  assign ovf_pos = |quot[NUM_W-1:FORCE_W-1];
  assign ovf_neg = (|quot[NUM_W-1:FORCE_W]) || (quot[FORCE_W-1] && (|quot[FORCE_W-2:0]));

  always_comb begin
    if (num_zero) begin
      conv_next = '0;
    end else if (q_neg) begin
      conv_next = ovf_neg ? FORCE_MIN : -$signed(quot[FORCE_W-1:0]);
    end else begin
      conv_next = ovf_pos ? FORCE_MAX : $signed(quot[FORCE_W-1:0]);
    end
  end

  // filter update: arithmetic shift gives floor of the scaled difference
  assign fd    = {conv_force[FORCE_W-1], conv_force} - {filtered_force[FORCE_W-1], filtered_force};
  assign fstep = fd >>> FILTER_SHIFT;
  assign fsum  = {fstep[FORCE_W], fstep} + {{2{filtered_force[FORCE_W-1]}}, filtered_force};

  always_comb begin
    if (fsum > $signed({2'b00, FORCE_MAX})) begin
      filt_next = FORCE_MAX;
    end else if (fsum < $signed({2'b11, FORCE_MIN})) begin
      filt_next = FORCE_MIN;
    end else begin
      filt_next = fsum[FORCE_W-1:0];
    end
  end

  // stale zeroing, deadband and clamp of negative force; calibration mode bypasses deadband and clamp
  assign f_abs = filtered_force[FORCE_W-1] ?
                 (FORCE_W+1)'(-{filtered_force[FORCE_W-1], filtered_force}) :
                 {1'b0, filtered_force};

  always_comb begin
    if (st_code == ST_STALE) begin
      pub_force = '0;
    end else if (calibration_mode) begin
      pub_force = filtered_force;
    end else if (f_abs <= {{(FORCE_W+1-DB_W){1'b0}}, deadband_q16}) begin
      pub_force = '0;
    end else if (filtered_force[FORCE_W-1]) begin
      pub_force = '0;
    end else begin
      pub_force = filtered_force;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      calibration_mode <= CAL_MODE_RST;
      zero_offset      <= ZERO_OFFSET_RST;
      counts_per_lb    <= CPL_RST;
      deadband_q16     <= DEADBAND_RST;
      stale_limit_ms   <= STALE_LIMIT_RST;
      filtered_force   <= '0;
      filter_primed    <= 1'b0;
      last_fresh_time  <= '0;
      st_code          <= ST_FRESH;
    end else begin
      if (state == S_PUB && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_CAL_MODE: begin
            calibration_mode <= cfg_wdata[0];
          end
          REG_ZERO_OFFSET: begin
            zero_offset    <= $signed(cfg_wdata[RAW_W-1:0]);
            filtered_force <= '0;
            filter_primed  <= 1'b0;
          end
          REG_CPL: begin
            counts_per_lb  <= $signed(cfg_wdata[CPL_W-1:0]);
            filtered_force <= '0;
            filter_primed  <= 1'b0;
          end
          REG_DEADBAND: begin
            deadband_q16 <= cfg_wdata[DB_W-1:0];
          end
          REG_STALE_LIMIT: begin
            stale_limit_ms <= cfg_wdata[STALE_W-1:0];
          end
          default: begin
          end
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (sample_ready) begin
              state <= S_DIV;
            end else begin
              state <= S_PUB;
              if (held_ok) begin
                st_code <= ST_HELD;
              end else begin
                st_code        <= ST_STALE;
                filtered_force <= '0;
                filter_primed  <= 1'b0;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          state <= S_FILT;
        end
        S_FILT: begin
          if (filter_primed) begin
            filtered_force <= filt_next;
          end else begin
            filtered_force <= conv_force;
            filter_primed  <= 1'b1;
          end
          last_fresh_time <= now_lat;
          st_code         <= ST_FRESH;
          state           <= S_PUB;
        end
        S_PUB: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_lat  <= now_ms;
      q_neg    <= diff[DIFF_W-1] ^ counts_per_lb[CPL_W-1];
      num_zero <= (diff_mag == '0);
    end
    if (state == S_CONV) begin
      conv_force <= conv_next;
    end
    if (state == S_PUB && out_free) begin
      force_out  <= pub_force;
      status_out <= st_code;
    end
  end

`ifndef SYNTH
  a_poll_to_pub: assert property (@(posedge clk) disable iff (rst)
    accept && !sample_ready |=> state == S_PUB)
    else $error("poll without sample did not go straight to publish");

  a_pub_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_PUB && out_valid && !out_ready |=> state == S_PUB && out_valid)
    else $error("publish step overran an untaken result");

  a_unprimed_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !filter_primed |-> filtered_force == '0)
    else $error("unprimed filter holds a non-zero value");

  a_stale_zero: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && status_out == ST_STALE |-> force_out == '0)
    else $error("stale result carries a non-zero force");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");
`endif

endmodule
`default_nettype wire
